// ----- hw/rtl/hec_pkg.sv -----
// Shared types and constants for the histogram-equalized colouring core.
// No dependencies; used by histogram_equalized_colouring_core.
package hec_pkg;

  localparam int MAX_ITER_DEF = 1024;

  localparam int FUNC_W = 2;
  localparam int IC_W   = 11;
  localparam int CNT_W  = 21;
  localparam int CH_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_FULL = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_COUNT  = 2'd0,
    FUNC_COLOUR = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_START_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_RED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_GREEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BLUE    = 3'd5;

  localparam logic [CH_W-1:0] RST_START_RED   = 8'd150;
  localparam logic [CH_W-1:0] RST_START_GREEN = 8'd0;
  localparam logic [CH_W-1:0] RST_START_BLUE  = 8'd230;
  localparam logic [CH_W-1:0] RST_END_RED     = 8'd0;
  localparam logic [CH_W-1:0] RST_END_GREEN   = 8'd255;
  localparam logic [CH_W-1:0] RST_END_BLUE    = 8'd255;

  // channel slots in the colour arrays
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

endpackage

// ----- hw/rtl/histogram_equalized_colouring_core.sv -----
// Histogram-equalized colouring core: histogram RAM, running total, and one
// shared multiply-add / restoring-divide unit under a sequencer.
// Depends on hec_pkg.
//
// Sequence: a count item reads its bin, then writes it back incremented; a clear
//   item writes zero to every bin; a colour item for count n sums bins 0..n into
//   the cumulative count, then runs the multiply-add and restoring divide for each
//   channel (skipped on an empty histogram); a black pixel needs no bin walk.
//   One item at a time: the single read port of the histogram RAM sets the bin walk.
// Flow: next item accepted the cycle busy falls; results cannot stall.
// Reset: synchronous; after reset the core runs a clearing pass over the
//   histogram RAM (busy high); config writes always taken.
module histogram_equalized_colouring_core #(
  parameter int MAX_ITER = hec_pkg::MAX_ITER_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [hec_pkg::FUNC_W-1:0]     in_func,
  input  logic [hec_pkg::IC_W-1:0]       in_iteration_count,
  output logic                           out_valid,
  output logic [hec_pkg::CH_W-1:0]       out_red,
  output logic [hec_pkg::CH_W-1:0]       out_green,
  output logic [hec_pkg::CH_W-1:0]       out_blue,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hec_pkg::CH_W-1:0]       cfg_data
);

  localparam int IDX_W  = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
  localparam int CNT_W  = hec_pkg::CNT_W;
  localparam int CH_W   = hec_pkg::CH_W;
  localparam int NUM_W  = CNT_W + CH_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ITER - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_CNT_RD, ST_CNT_WR, ST_SUM, ST_SUM_DRAIN,
    ST_MUL_A, ST_MUL_B, ST_DIV
  } state_t;

  // histogram RAM
  logic [CNT_W-1:0] bin_mem [MAX_ITER];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [CNT_W-1:0] rdata_r;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] ic_r, ic_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CH_W-1:0]  lo_r, lo_nxt;
  logic [CH_W-1:0]  quot_r, quot_nxt;
  logic [CH_W-1:0]  col_r [3];
  logic [CH_W-1:0]  col_nxt [3];
  logic [CH_W-1:0]  start_r [3];
  logic [CH_W-1:0]  end_r [3];
  logic             out_valid_r, out_valid_nxt;

  logic             accept;
  logic [CH_W-1:0]  mul_a;
  logic [CNT_W-1:0] mul_b;
  logic [NUM_W-1:0] prod;
  logic [NUM_W-1:0] num_full;
  logic [CNT_W:0]   div_sh;
  logic             div_ge;
  logic [CNT_W:0]   div_sub;
  logic [CH_W-1:0]  quot_fin;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_red   = col_r[hec_pkg::CH_RED];
  assign out_green = col_r[hec_pkg::CH_GREEN];
  assign out_blue  = col_r[hec_pkg::CH_BLUE];

  // shared multiply-add: start*(total-cum), then + end*cum
  assign mul_a    = (state_r == ST_MUL_A) ? start_r[ch_r] : end_r[ch_r];
  assign mul_b    = (state_r == ST_MUL_A) ? (total_r - acc_r) : acc_r;
  assign prod     = NUM_W'(mul_a) * NUM_W'(mul_b);
  assign num_full = num_r + prod;

  // one restoring divide step; remainder always below total
  assign div_sh   = {rem_r, lo_r[CH_W-1]};
  assign div_ge   = (div_sh >= {1'b0, total_r});
  assign div_sub  = div_sh - {1'b0, total_r};
  assign quot_fin = {quot_r[CH_W-2:0], div_ge};

  assign mem_raddr = (state_r == ST_SUM) ? idx_r : ic_r;

  always_comb begin
    state_nxt     = state_r;
    ic_nxt        = ic_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r + (rd_vld_r ? rdata_r : '0);
    rd_vld_nxt    = 1'b0;
    ch_nxt        = ch_r;
    step_nxt      = step_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    lo_nxt        = lo_r;
    quot_nxt      = quot_r;
    col_nxt       = col_r;
    out_valid_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ic_nxt  = IDX_W'(in_iteration_count);
          idx_nxt = '0;
          acc_nxt = '0;
          case (in_func)
            hec_pkg::FUNC_COUNT: begin
              if (32'(in_iteration_count) < 32'(MAX_ITER) &&
                  total_r != hec_pkg::COUNT_FULL) begin
                state_nxt = ST_CNT_RD;
              end
            end
            hec_pkg::FUNC_COLOUR: begin
              if (32'(in_iteration_count) >= 32'(MAX_ITER)) begin
                col_nxt[hec_pkg::CH_RED]   = '0;
                col_nxt[hec_pkg::CH_GREEN] = '0;
                col_nxt[hec_pkg::CH_BLUE]  = '0;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_SUM;
              end
            end
            hec_pkg::FUNC_CLEAR: begin
              total_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CNT_RD: begin
        state_nxt = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ic_r;
        mem_wdata = rdata_r + 1'b1;
        total_nxt = total_r + 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        rd_vld_nxt = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == ic_r) begin
          state_nxt = ST_SUM_DRAIN;
        end
      end
      ST_SUM_DRAIN: begin
        ch_nxt    = hec_pkg::CH_RED;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        if (total_r == '0) begin
          // empty histogram: share is zero, start colour as is
          col_nxt[ch_r] = start_r[ch_r];
          if (ch_r == hec_pkg::CH_BLUE) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            ch_nxt = ch_r + 1'b1;
          end
        end else begin
          num_nxt   = prod;
          state_nxt = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        rem_nxt   = num_full[NUM_W-1:CH_W];
        lo_nxt    = num_full[CH_W-1:0];
        quot_nxt  = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0];
        lo_nxt   = {lo_r[CH_W-2:0], 1'b0};
        quot_nxt = quot_fin;
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd7) begin
          col_nxt[ch_r] = quot_fin;
          if (ch_r == hec_pkg::CH_BLUE) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_MUL_A;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      total_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      start_r[hec_pkg::CH_RED]   <= hec_pkg::RST_START_RED;
      start_r[hec_pkg::CH_GREEN] <= hec_pkg::RST_START_GREEN;
      start_r[hec_pkg::CH_BLUE]  <= hec_pkg::RST_START_BLUE;
      end_r[hec_pkg::CH_RED]     <= hec_pkg::RST_END_RED;
      end_r[hec_pkg::CH_GREEN]   <= hec_pkg::RST_END_GREEN;
      end_r[hec_pkg::CH_BLUE]    <= hec_pkg::RST_END_BLUE;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          hec_pkg::CFG_START_RED:   start_r[hec_pkg::CH_RED]   <= cfg_data;
          hec_pkg::CFG_START_GREEN: start_r[hec_pkg::CH_GREEN] <= cfg_data;
          hec_pkg::CFG_START_BLUE:  start_r[hec_pkg::CH_BLUE]  <= cfg_data;
          hec_pkg::CFG_END_RED:     end_r[hec_pkg::CH_RED]     <= cfg_data;
          hec_pkg::CFG_END_GREEN:   end_r[hec_pkg::CH_GREEN]   <= cfg_data;
          hec_pkg::CFG_END_BLUE:    end_r[hec_pkg::CH_BLUE]    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    // datapath, no reset needed
    ic_r   <= ic_nxt;
    acc_r  <= acc_nxt;
    ch_r   <= ch_nxt;
    step_r <= step_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    quot_r <= quot_nxt;
    col_r  <= col_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= bin_mem[mem_raddr];
  end

  // a result only leaves an idle core
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while core busy");

  // a bin can never hold more than the running total
  a_bin_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CNT_WR |-> rdata_r <= total_r)
    else $error("histogram bin exceeds total");

  // cumulative share never exceeds the total
  a_cum_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_A |-> acc_r <= total_r)
    else $error("cumulative count exceeds total");

  // a clear item starts the clearing pass and zeroes the total
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == hec_pkg::FUNC_CLEAR) |=> (busy && total_r == '0))
    else $error("clear item did not start clearing pass");

endmodule

// ----- verif/tb.sv -----
// Testbench for histogram_equalized_colouring_core: directed and random item streams
// checked against a cycle-free predictor of the histogram and colour blend.
// Depends on hec_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_ITER     = hec_pkg::MAX_ITER_DEF;
  localparam int FUNC_W       = hec_pkg::FUNC_W;
  localparam int IC_W         = hec_pkg::IC_W;
  localparam int CNT_W        = hec_pkg::CNT_W;
  localparam int CH_W         = hec_pkg::CH_W;
  localparam int CFG_IDX_W    = hec_pkg::CFG_IDX_W;
  localparam int ITEM_TARGET  = 540;
  localparam int TAIL_ITEMS   = 80;
  localparam int DRAIN_CYCLES = 1100;
  localparam int STALL_LIMIT  = 20000;

  // indexes past the last register; the core must drop these writes
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [FUNC_W-1:0]    in_func = hec_pkg::FUNC_COUNT;
  logic [IC_W-1:0]      in_iteration_count = '0;
  logic                 out_valid;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CH_W-1:0]      cfg_data = '0;

  // predictor state
  logic [CNT_W-1:0] hist_bins [MAX_ITER];
  logic [CNT_W-1:0] hist_total;
  logic [CH_W-1:0]  start_colour [3];
  logic [CH_W-1:0]  end_colour [3];

  pixel_t expected_pixels [$];
  int     fail_count = 0;
  int     item_count = 0;
  int     stall_cycles = 0;
  bit     idle_on = 1'b1;

  histogram_equalized_colouring_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_iteration_count (in_iteration_count),
    .out_valid          (out_valid),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_histogram;
    for (int i = 0; i < MAX_ITER; i++) hist_bins[i] = '0;
    hist_total = '0;
  endtask

  function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] s,
                                                    input logic [CH_W-1:0] e,
                                                    input logic [63:0] cum,
                                                    input logic [63:0] total);
    if (total == 0) return s;
    return CH_W'((64'(s) * (total - cum) + 64'(e) * cum) / total);
  endfunction

  function automatic pixel_t predict_pixel(input logic [IC_W-1:0] ic);
    logic [63:0] cum;
    pixel_t      p;
    if (ic >= MAX_ITER) return '0;  // never escaped: black
    cum = '0;
    for (int i = 0; i <= ic; i++) cum += hist_bins[i];
    if (cum > hist_total) cum = hist_total;
    p.red   = blend_channel(start_colour[hec_pkg::CH_RED], end_colour[hec_pkg::CH_RED],
                            cum, hist_total);
    p.green = blend_channel(start_colour[hec_pkg::CH_GREEN], end_colour[hec_pkg::CH_GREEN],
                            cum, hist_total);
    p.blue  = blend_channel(start_colour[hec_pkg::CH_BLUE], end_colour[hec_pkg::CH_BLUE],
                            cum, hist_total);
    return p;
  endfunction

  function automatic logic [IC_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 55) return IC_W'($urandom_range(31));
    if (r < 80) return IC_W'($urandom_range(MAX_ITER - 1));
    if (r < 88) return ($urandom_range(1) != 0) ? IC_W'(MAX_ITER - 1) : '0;
    if (r < 94) return IC_W'(MAX_ITER);
    return IC_W'($urandom_range(MAX_ITER + 1, 2047));
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // one item: optional idle burst, then hold start until the core takes it
  task automatic send_item(input hec_pkg::func_t f, input logic [IC_W-1:0] ic);
    if (idle_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_iteration_count <= ic;
    do @(posedge clk); while (busy !== 1'b0);
    item_count++;
    case (f)
      hec_pkg::FUNC_COUNT: begin
        if (ic < MAX_ITER && hist_total != hec_pkg::COUNT_FULL) begin
          hist_bins[ic] = hist_bins[ic] + 1'b1;
          hist_total = hist_total + 1'b1;
        end
      end
      hec_pkg::FUNC_COLOUR: begin
        expected_pixels.push_back(predict_pixel(ic));
      end
      hec_pkg::FUNC_CLEAR: begin
        clear_histogram();
      end
      default: ;
    endcase
  endtask

  // leaves cfg_valid high so back-to-back writes never toggle it within a step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      hec_pkg::CFG_START_RED:   start_colour[hec_pkg::CH_RED] = data;
      hec_pkg::CFG_START_GREEN: start_colour[hec_pkg::CH_GREEN] = data;
      hec_pkg::CFG_START_BLUE:  start_colour[hec_pkg::CH_BLUE] = data;
      hec_pkg::CFG_END_RED:     end_colour[hec_pkg::CH_RED] = data;
      hec_pkg::CFG_END_GREEN:   end_colour[hec_pkg::CH_GREEN] = data;
      hec_pkg::CFG_END_BLUE:    end_colour[hec_pkg::CH_BLUE] = data;
      default: ;
    endcase
  endtask

  task automatic set_colours(input logic [CH_W-1:0] sr, input logic [CH_W-1:0] sg,
                             input logic [CH_W-1:0] sb, input logic [CH_W-1:0] er,
                             input logic [CH_W-1:0] eg, input logic [CH_W-1:0] eb);
    write_reg(hec_pkg::CFG_START_RED, sr);
    write_reg(hec_pkg::CFG_START_GREEN, sg);
    write_reg(hec_pkg::CFG_START_BLUE, sb);
    write_reg(hec_pkg::CFG_END_RED, er);
    write_reg(hec_pkg::CFG_END_GREEN, eg);
    write_reg(hec_pkg::CFG_END_BLUE, eb);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle;
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    // count and clear items give no result; give a trailing one time to finish
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_histogram;
    send_item(hec_pkg::FUNC_COLOUR, '0);
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(MAX_ITER - 1));
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(MAX_ITER));
    send_item(hec_pkg::FUNC_COLOUR, '1);
    send_item(hec_pkg::FUNC_NONE, '1);
  endtask

  task automatic test_count_and_colour;
    send_item(hec_pkg::FUNC_COUNT, '0);
    send_item(hec_pkg::FUNC_COUNT, IC_W'(MAX_ITER - 1));
    send_item(hec_pkg::FUNC_COUNT, IC_W'(MAX_ITER));
    send_item(hec_pkg::FUNC_COUNT, '1);
    send_item(hec_pkg::FUNC_COUNT, IC_W'(512));
    send_item(hec_pkg::FUNC_COUNT, IC_W'(512));
    send_item(hec_pkg::FUNC_COUNT, '0);
    send_item(hec_pkg::FUNC_COLOUR, '0);
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(511));
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(512));
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(MAX_ITER - 1));
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(MAX_ITER));
  endtask

  task automatic test_config_registers;
    wait_idle();
    write_reg(CFG_SPARE_LO, 8'hFF);
    write_reg(CFG_SPARE_HI, 8'h5A);
    set_colours(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(hec_pkg::FUNC_COLOUR, '0);
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(512));
    wait_idle();
    set_colours(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(512));
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(MAX_ITER - 1));
  endtask

  task automatic test_clear;
    send_item(hec_pkg::FUNC_CLEAR, '0);
    send_item(hec_pkg::FUNC_COLOUR, IC_W'(MAX_ITER - 1));
  endtask

  task automatic reconfigure;
    int r;
    r = $urandom_range(5);
    wait_idle();
    if ($urandom_range(2) == 0)
      write_reg(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                CH_W'($urandom_range(255)));
    case (r)
      0: set_colours(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      1: set_colours(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      2: set_colours(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
      default: set_colours(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                           CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                           CH_W'($urandom_range(255)), CH_W'($urandom_range(255)));
    endcase
  endtask

  // a frame: maybe clear, fill the histogram, then colour pixels; some noise mixed in
  task automatic run_frame;
    int n;
    int r;
    if ($urandom_range(3) == 0)
      send_item(hec_pkg::FUNC_CLEAR, IC_W'($urandom_range(2047)));
    n = $urandom_range(4, 40);
    repeat (n) begin
      r = $urandom_range(19);
      if (r == 0) send_item(hec_pkg::FUNC_NONE, IC_W'($urandom_range(2047)));
      else send_item(hec_pkg::FUNC_COUNT, pick_count());
    end
    n = $urandom_range(2, 12);
    repeat (n) begin
      r = $urandom_range(15);
      if (r == 0) send_item(hec_pkg::FUNC_NONE, IC_W'($urandom_range(2047)));
      else if (r == 1) send_item(hec_pkg::FUNC_COUNT, pick_count());
      else send_item(hec_pkg::FUNC_COLOUR, pick_count());
    end
  endtask

  task automatic test_random_frames;
    int frame_no;
    frame_no = 0;
    while (item_count < ITEM_TARGET) begin
      idle_on = (item_count < ITEM_TARGET - TAIL_ITEMS) && ($urandom_range(3) != 0);
      if (frame_no % 6 == 5 && item_count < ITEM_TARGET - TAIL_ITEMS) reconfigure();
      run_frame();
      frame_no++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("unexpected pixel r=%0d g=%0d b=%0d",
                               out_red, out_green, out_blue));
      end else begin
        want = expected_pixels.pop_front();
        if (out_red !== want.red)
          note_failure($sformatf("red exp %0d got %0d", want.red, out_red));
        if (out_green !== want.green)
          note_failure($sformatf("green exp %0d got %0d", want.green, out_green));
        if (out_blue !== want.blue)
          note_failure($sformatf("blue exp %0d got %0d", want.blue, out_blue));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_histogram();
    start_colour[hec_pkg::CH_RED]   = hec_pkg::RST_START_RED;
    start_colour[hec_pkg::CH_GREEN] = hec_pkg::RST_START_GREEN;
    start_colour[hec_pkg::CH_BLUE]  = hec_pkg::RST_START_BLUE;
    end_colour[hec_pkg::CH_RED]     = hec_pkg::RST_END_RED;
    end_colour[hec_pkg::CH_GREEN]   = hec_pkg::RST_END_GREEN;
    end_colour[hec_pkg::CH_BLUE]    = hec_pkg::RST_END_BLUE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_histogram();
    test_count_and_colour();
    test_config_registers();
    test_clear();
    test_random_frames();

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
